// ===== hw/rtl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants of the linear scan spill selector
// Beat formats, entry layout, spill rule codes, register indexes, FSM states.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int MAX_REGISTERS = 16;
    localparam int POINT_BITS    = 16;

    localparam int IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
    localparam int CNT_W = $clog2(MAX_REGISTERS + 1);
    localparam int TOT_W = $clog2(MAX_REGISTERS + 2);

    // Spill rule codes; the unused code behaves as the newcomer rule.
    localparam logic [1:0] RULE_NEWCOMER = 2'd0;
    localparam logic [1:0] RULE_FURTHEST = 2'd1;
    localparam logic [1:0] RULE_FEWEST   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic CFG_SPILL_RULE = 1'b0;
    localparam logic CFG_REG_COUNT  = 1'b1;

    localparam logic [1:0] SPILL_RULE_RESET = RULE_FURTHEST;
    localparam logic [4:0] REG_COUNT_RESET  = 5'd2;

    typedef logic [POINT_BITS-1:0] t_point;

    typedef struct packed {
        logic [15:0] interval_id;
        logic [15:0] start_point;
        logic [15:0] end_point;
        logic [15:0] use_count;
        logic        new_run;
    } t_in_beat;

    typedef struct packed {
        logic        spill_valid;
        logic [15:0] victim_id;
        logic        victim_was_newcomer;
        logic [4:0]  active_count;
        logic [15:0] spilled_total;
        logic [31:0] access_total;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] id;
        t_point      end_pt;
        logic [15:0] uses;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_SHIFT,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan;
        logic pick;
        logic shift;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic need_shift;
        logic shift_done;
        logic out_free;
    } t_dp_status;

    // True when the candidate displaces the current best victim. Ties keep
    // the earlier candidate.
    function automatic logic beats_best(input logic [1:0] rule,
                                        input t_point cand_end,
                                        input logic [15:0] cand_uses,
                                        input t_point best_end,
                                        input logic [15:0] best_uses);
        logic res;
        unique case (rule)
            RULE_FURTHEST: res = (cand_end > best_end);
            RULE_FEWEST:   res = (cand_uses < best_uses) ||
                                 ((cand_uses == best_uses) && (cand_end > best_end));
            default:       res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/lss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lss_ctrl: sequencer of the linear scan spill selector
// Steps one interval through scan, victim pick, compaction and write-back.
// ----------------------------------------------------------------------------
module lss_ctrl
    import lss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_PICK;
            end
            ST_PICK: begin
                n_state = i_status.need_shift ? ST_SHIFT : ST_WRITE;
            end
            ST_SHIFT: begin
                if (i_status.shift_done) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SCAN:  o_cmd.scan   = !i_status.scan_done;
            ST_PICK:  o_cmd.pick   = 1'b1;
            ST_SHIFT: o_cmd.shift  = !i_status.shift_done;
            ST_WRITE: o_cmd.finish = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lss_datapath.sv =====
// ----------------------------------------------------------------------------
// lss_datapath: active set storage, victim search and running totals
// Holds the compacted active set, one read and one write per cycle.
// ----------------------------------------------------------------------------
module lss_datapath
    import lss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_beat   i_in_data,
    input  logic [1:0] i_spill_rule,
    input  logic [4:0] i_register_count,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data
);

    t_entry            r_ent [MAX_REGISTERS];
    t_entry            r_new;
    t_point            r_start;
    logic [CNT_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_wr;
    logic [CNT_W-1:0]  r_live;
    logic              r_have_best;
    t_entry            r_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic              r_spill;
    logic              r_victim_new;
    logic [15:0]       r_vic_id;
    logic [15:0]       r_vic_uses;
    logic [15:0]       r_spill_cnt;
    logic [31:0]       r_acc_cnt;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [CNT_W-1:0]  rd_next;
    logic [IDX_W-1:0]  rd_idx;
    t_entry            rd_ent;
    logic              keep;
    logic              cand_wins;
    logic              new_wins;
    logic              out_free;
    logic [CNT_W-1:0]  regs_cap;
    logic [TOT_W-1:0]  total;
    logic              spill_now;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    t_entry            wdata;
    logic [CNT_W-1:0]  wr_dec;
    logic [CNT_W-1:0]  n_live;
    logic [15:0]       n_spill_cnt;
    logic [31:0]       n_acc_cnt;
    logic [32:0]       acc_sum;

    function automatic logic [CNT_W-1:0] rd_wr_inc(input logic [CNT_W-1:0] v);
        return v + CNT_W'(1);
    endfunction

    assign rd_next = r_rd + CNT_W'(1);
    assign rd_idx  = i_cmd.shift ? rd_next[IDX_W-1:0] : r_rd[IDX_W-1:0];
    assign rd_ent  = r_ent[rd_idx];
    assign wr_dec  = r_wr - CNT_W'(1);

    // An entry stays active unless its end lies before the new start.
    assign keep      = !(rd_ent.end_pt < r_start);
    assign cand_wins = !r_have_best ||
                       beats_best(i_spill_rule, rd_ent.end_pt, rd_ent.uses,
                                  r_best.end_pt, r_best.uses);

    // The newcomer is the latest candidate, so it must strictly beat the best.
    assign new_wins = ((i_spill_rule != RULE_FURTHEST) && (i_spill_rule != RULE_FEWEST)) ||
                      !r_have_best ||
                      beats_best(i_spill_rule, r_new.end_pt, r_new.uses,
                                 r_best.end_pt, r_best.uses);

    assign regs_cap  = ({27'd0, i_register_count} > MAX_REGISTERS) ?
                       CNT_W'(MAX_REGISTERS) : CNT_W'(i_register_count);
    assign total     = TOT_W'(r_wr) + TOT_W'(1);
    assign spill_now = total > TOT_W'(regs_cap);

    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.scan_done  = (r_rd == r_live);
    assign o_status.need_shift = spill_now && !new_wins;
    assign o_status.shift_done = ({1'b0, rd_next} >= {1'b0, r_wr});
    assign o_status.out_free   = out_free;

    assign n_live      = r_spill ? r_wr : rd_wr_inc(r_wr);
    assign n_spill_cnt = (r_spill && (r_spill_cnt != 16'hFFFF)) ?
                         r_spill_cnt + 16'd1 : r_spill_cnt;
    assign acc_sum     = {1'b0, r_acc_cnt} + {17'd0, r_vic_uses};
    assign n_acc_cnt   = !r_spill ? r_acc_cnt :
                         (acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0]);

    always_comb begin
        we    = 1'b0;
        waddr = r_wr[IDX_W-1:0];
        wdata = rd_ent;
        if (i_cmd.scan) begin
            we = keep;
        end else if (i_cmd.shift) begin
            we    = 1'b1;
            waddr = r_rd[IDX_W-1:0];
        end else if (i_cmd.finish) begin
            we    = !r_victim_new;
            waddr = r_spill ? wr_dec[IDX_W-1:0] : r_wr[IDX_W-1:0];
            wdata = r_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ent[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new.id     <= i_in_data.interval_id;
            r_new.end_pt <= i_in_data.end_point[POINT_BITS-1:0];
            r_new.uses   <= i_in_data.use_count;
            r_start      <= i_in_data.start_point[POINT_BITS-1:0];
            r_rd         <= '0;
            r_wr         <= '0;
            r_have_best  <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_rd <= rd_next;
            if (keep) begin
                r_wr <= rd_wr_inc(r_wr);
                if (cand_wins) begin
                    r_best      <= rd_ent;
                    r_best_idx  <= r_wr[IDX_W-1:0];
                    r_have_best <= 1'b1;
                end
            end
        end
        if (i_cmd.pick) begin
            r_spill      <= spill_now;
            r_victim_new <= spill_now && new_wins;
            r_vic_id     <= new_wins ? r_new.id : r_best.id;
            r_vic_uses   <= new_wins ? r_new.uses : r_best.uses;
            r_rd         <= CNT_W'(r_best_idx);
        end
        if (i_cmd.shift) begin
            r_rd <= rd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_spill_cnt <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_in_data.new_run) begin
                r_live      <= '0;
                r_spill_cnt <= '0;
                r_acc_cnt   <= '0;
            end
            if (i_cmd.finish) begin
                r_live      <= n_live;
                r_spill_cnt <= n_spill_cnt;
                r_acc_cnt   <= n_acc_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.spill_valid         <= r_spill;
            r_out.victim_id           <= r_spill ? r_vic_id : 16'd0;
            r_out.victim_was_newcomer <= r_victim_new;
            r_out.active_count        <= 5'(n_live);
            r_out.spilled_total       <= n_spill_cnt;
            r_out.access_total        <= n_acc_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/linear_scan_spill_selector_top.sv =====
// ----------------------------------------------------------------------------
// linear_scan_spill_selector_top: linear scan spill selector
// Keeps the active set of live intervals and picks one victim on overflow.
// ----------------------------------------------------------------------------
// Live intervals enter as beats on the valid/ready input channel, sorted by
// start point. Each accepted beat yields exactly one result beat on the
// valid/ready output channel: spill flag, victim id, active count and the
// saturating totals of spills and spilled uses.
// One interval is in work at a time. The sequencer scans the active set for
// expiry and the best victim, picks the victim, compacts the set when a
// stored entry is spilled, and writes back; the next beat is taken in the
// following cycle. The scan and compaction share the single read and write
// port of the entry store.
// The result sits in an output register; the next interval is accepted and
// processed while it waits, and only its write-back stalls until the
// receiver takes the pending beat.
// Reset empties the active set, clears both totals and sets the spill rule
// to furthest end and the register count to two. Registers are written on
// the APB port at byte 0 (spill rule) and byte 4 (register count).
// ----------------------------------------------------------------------------
module linear_scan_spill_selector_top
    import lss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] r_spill_rule;
    logic [4:0] r_reg_count;
    logic       cfg_wr;
    t_dp_cmd    cmd;
    t_dp_status status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spill_rule <= SPILL_RULE_RESET;
            r_reg_count  <= REG_COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_SPILL_RULE: r_spill_rule <= pwdata[1:0];
                CFG_REG_COUNT:  r_reg_count  <= pwdata[4:0];
                default:        r_reg_count  <= r_reg_count;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_SPILL_RULE: prdata = {30'd0, r_spill_rule};
            CFG_REG_COUNT:  prdata = {27'd0, r_reg_count};
            default:        prdata = 32'd0;
        endcase
    end

    lss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lss_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_data        (i_in_data),
        .i_spill_rule     (r_spill_rule),
        .i_register_count (r_reg_count),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_data       (o_out_data)
    );

endmodule
